/* design/wsd_pkg.sv */
package wsd_pkg;

  localparam int LENGTH_BITS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_DATA = 3'd3,
    PH_SKIP = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_NONE = 2'h0;
  localparam logic [1:0] KIND_TEXT = 2'h1;
  localparam logic [1:0] KIND_BIN  = 2'h2;

  localparam logic [3:0] OPC_TEXT = 4'h1;
  localparam logic [3:0] OPC_BIN  = 4'h2;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT_BYTES16 = 4'd2;
  localparam logic [3:0] EXT_BYTES64 = 4'd8;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_kind;
    logic       has_byte;
    logic       last_of_frame;
  } result_t;

endpackage

/* design/wsd_front.sv */
module wsd_front #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output logic             push,
  output wsd_pkg::result_t push_item
);

  wsd_pkg::phase_t        phase, phase_next;
  logic [1:0]             kind_flags, kind_flags_next;
  logic [3:0]             ext_left, ext_left_next;
  logic [LENGTH_BITS-1:0] rem_len, rem_len_next;

  logic [6:0]             len7;
  logic [LENGTH_BITS-1:0] hdr_len, ext_len, dec_len;
  logic                   defined, kind_bit, ext_done, emit;

  assign len7     = rx_byte[6:0];
  assign hdr_len  = {{(LENGTH_BITS-7){1'b0}}, len7};
  assign ext_len  = {rem_len[LENGTH_BITS-9:0], rx_byte};
  assign dec_len  = rem_len - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign defined  = (kind_flags == wsd_pkg::KIND_TEXT) || (kind_flags == wsd_pkg::KIND_BIN);
  assign kind_bit = (kind_flags == wsd_pkg::KIND_BIN);
  assign ext_done = (ext_left == 4'd1);

  always_comb begin
    phase_next = phase;
    case (phase)
      wsd_pkg::PH_HDR1: begin
        if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
          phase_next = wsd_pkg::PH_EXT;
        end else if (len7 == 7'd0) begin
          phase_next = wsd_pkg::PH_HDR0;
        end else begin
          phase_next = defined ? wsd_pkg::PH_DATA : wsd_pkg::PH_SKIP;
        end
      end
      wsd_pkg::PH_EXT: begin
        if (ext_done) begin
          if (ext_len == '0) begin
            phase_next = wsd_pkg::PH_HDR0;
          end else begin
            phase_next = defined ? wsd_pkg::PH_DATA : wsd_pkg::PH_SKIP;
          end
        end
      end
      wsd_pkg::PH_DATA, wsd_pkg::PH_SKIP: begin
        if (dec_len == '0) begin
          phase_next = wsd_pkg::PH_HDR0;
        end
      end
      default: begin
        phase_next = wsd_pkg::PH_HDR1;
      end
    endcase
  end

  always_comb begin
    kind_flags_next = kind_flags;
    ext_left_next   = ext_left;
    rem_len_next    = rem_len;
    emit            = 1'b0;
    push_item       = '{payload_byte: 8'h00, frame_kind: kind_bit,
                        has_byte: 1'b0, last_of_frame: 1'b1};
    case (phase)
      wsd_pkg::PH_HDR1: begin
        if (len7 == wsd_pkg::LEN_EXT16) begin
          ext_left_next = wsd_pkg::EXT_BYTES16;
          rem_len_next  = '0;
        end else if (len7 == wsd_pkg::LEN_EXT64) begin
          ext_left_next = wsd_pkg::EXT_BYTES64;
          rem_len_next  = '0;
        end else begin
          rem_len_next = hdr_len;
          emit         = (len7 == 7'd0) && defined;
        end
      end
      wsd_pkg::PH_EXT: begin
        rem_len_next  = ext_len;
        ext_left_next = ext_left - 4'd1;
        emit          = ext_done && (ext_len == '0) && defined;
      end
      wsd_pkg::PH_DATA: begin
        rem_len_next = dec_len;
        emit         = 1'b1;
        push_item    = '{payload_byte: rx_byte, frame_kind: kind_bit,
                         has_byte: 1'b1, last_of_frame: (dec_len == '0)};
      end
      wsd_pkg::PH_SKIP: begin
        rem_len_next = dec_len;
      end
      default: begin
        case (rx_byte[3:0])
          wsd_pkg::OPC_TEXT: kind_flags_next = wsd_pkg::KIND_TEXT;
          wsd_pkg::OPC_BIN:  kind_flags_next = wsd_pkg::KIND_BIN;
          default:           kind_flags_next = wsd_pkg::KIND_NONE;
        endcase
        ext_left_next = 4'd0;
      end
    endcase
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= wsd_pkg::PH_HDR0;
      kind_flags <= wsd_pkg::KIND_NONE;
      ext_left   <= 4'd0;
      rem_len    <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      kind_flags <= kind_flags_next;
      ext_left   <= ext_left_next;
      rem_len    <= rem_len_next;
    end
  end

  a_empty_marks_last: assert property (@(posedge clk) disable iff (rst)
    push && !push_item.has_byte |-> push_item.last_of_frame)
    else $error("empty-frame marker without last flag");

  a_last_to_header: assert property (@(posedge clk) disable iff (rst)
    push && push_item.last_of_frame |=> phase == wsd_pkg::PH_HDR0)
    else $error("frame ended but parser not back at header");

  a_data_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == wsd_pkg::PH_DATA || phase == wsd_pkg::PH_SKIP) |-> rem_len != '0)
    else $error("payload phase with zero length left");

  a_ext_count: assert property (@(posedge clk) disable iff (rst)
    phase == wsd_pkg::PH_EXT |-> (ext_left != 4'd0 && ext_left <= wsd_pkg::EXT_BYTES64))
    else $error("extended length count out of range");

endmodule

/* design/wsd_queue.sv */
module wsd_queue #(
  parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wsd_pkg::result_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output wsd_pkg::result_t head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsd_pkg::result_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count, count_next;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + CW'(1);
      2'b01:   count_next = count - CW'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count_next;
    end
  end

endmodule

/* design/wsd_back.sv */
module wsd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  wsd_pkg::result_t head_item,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [7:0]       payload_byte,
  output logic             frame_kind,
  output logic             has_byte,
  output logic             last_of_frame
);

  wsd_pkg::result_t hold;
  logic             load;

  assign load = !res_valid || !res_stall;
  assign pop  = head_valid && load;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= head_item;
    end
  end

  assign payload_byte  = hold.payload_byte;
  assign frame_kind    = hold.frame_kind;
  assign has_byte      = hold.has_byte;
  assign last_of_frame = hold.last_of_frame;

endmodule

/* design/websocket_frame_deframer.sv */
// channel  | handshake            | payload
// rx       | rx_valid / rx_stall  | rx_byte
// res      | res_valid / res_stall| payload_byte, frame_kind, has_byte, last_of_frame
//
// One byte accepted per cycle unless rx_stall; results are queued, then registered.
// The parser register holds the length loop: shift/decrement is combinational.
// rst is synchronous; parser returns to first header byte, queue and output empty.
// rx_stall rises only when the result queue (QUEUE_DEPTH entries) is full,
// which happens only while res_stall holds the output register.
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] payload_byte,
  output logic       frame_kind,
  output logic       has_byte,
  output logic       last_of_frame
);

  logic             accept, push, full, pop, head_valid;
  wsd_pkg::result_t push_item, head_item;

  assign rx_stall = full;
  assign accept   = rx_valid && !full;

  wsd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .push      (push),
    .push_item (push_item)
  );

  wsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  wsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .payload_byte  (payload_byte),
    .frame_kind    (frame_kind),
    .has_byte      (has_byte),
    .last_of_frame (last_of_frame)
  );

endmodule
